// ----- rtl/chpg_pkg.sv -----
// chpg_pkg: shared types and constants for the conical helix point generator
// holds register addresses, the cordic arctangent table and the pipeline beat types
// no dependencies
`default_nettype none
package chpg_pkg;

  localparam int unsigned IdxW   = 12;
  localparam int unsigned RadW   = 16;
  localparam int unsigned OutW   = 17;
  localparam int unsigned PhW    = 32;
  localparam int unsigned GainQ16 = 39797;
  localparam int unsigned MaxStages = 24;

  typedef enum logic [2:0] {
    RegStartRadius = 3'd0,
    RegEndRadius   = 3'd1,
    RegRiseHeight  = 3'd2,
    RegRevolutions = 3'd3,
    RegPointTotal  = 3'd4
  } reg_addr_e;

  function automatic logic [PhW-1:0] atan_turn(input int unsigned i);
    logic [PhW-1:0] v;
    begin
      case (i)
        0:  v = 32'd536870912;
        1:  v = 32'd316933406;
        2:  v = 32'd167458907;
        3:  v = 32'd85004756;
        4:  v = 32'd42667331;
        5:  v = 32'd21354465;
        6:  v = 32'd10679838;
        7:  v = 32'd5340245;
        8:  v = 32'd2670163;
        9:  v = 32'd1335087;
        10: v = 32'd667544;
        11: v = 32'd333772;
        12: v = 32'd166886;
        13: v = 32'd83443;
        14: v = 32'd41722;
        15: v = 32'd20861;
        16: v = 32'd10430;
        17: v = 32'd5215;
        18: v = 32'd2608;
        19: v = 32'd1304;
        20: v = 32'd652;
        21: v = 32'd326;
        22: v = 32'd163;
        23: v = 32'd81;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // side data that rides along every cell of the cordic chain
  typedef struct packed {
    logic                  err;
    logic                  last;
    logic [15:0]           pos_y;
  } side_t;

endpackage
`default_nettype wire

// ----- rtl/chpg_div_cell.sv -----
// chpg_div_cell: one restoring-divider step of the t = (index << F) / (total-1) chain
// no package dependencies
`default_nettype none
module chpg_div_cell #(
  parameter int unsigned NumW = 28,
  parameter int unsigned DenW = 12,
  parameter int unsigned Bit  = 0
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [NumW-1:0] quo_i,
  input  wire logic [DenW-1:0] den_i,
  input  wire logic [11:0]     idx_i,
  input  wire logic            err_i,
  input  wire logic            last_i,
  output logic      [NumW-1:0] num_o,
  output logic      [NumW-1:0] quo_o,
  output logic      [DenW-1:0] den_o,
  output logic      [11:0]     idx_o,
  output logic                 err_o,
  output logic                 last_o
);
  logic [NumW+DenW-1:0] den_sh;
  logic [NumW+DenW-1:0] num_ext;
  logic                 fit;
  logic [NumW-1:0]      num_d;
  logic [NumW-1:0]      quo_d;

  always_comb begin
    den_sh  = {{NumW{1'b0}}, den_i} << Bit;
    num_ext = {{DenW{1'b0}}, num_i};
    fit     = num_ext >= den_sh;
    num_d   = fit ? NumW'(num_ext - den_sh) : num_i;
    quo_d   = quo_i;
    quo_d[Bit] = fit;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o  <= num_d;
      quo_o  <= quo_d;
      den_o  <= den_i;
      idx_o  <= idx_i;
      err_o  <= err_i;
      last_o <= last_i;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/chpg_cordic_cell.sv -----
// chpg_cordic_cell: one rotation step of the cordic chain, floor shifts
// depends on chpg_pkg for the arctangent table and side-data type
`default_nettype none
module chpg_cordic_cell #(
  parameter int unsigned VecW  = 40,
  parameter int unsigned Stage = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic signed [VecW-1:0] x_i,
  input  wire logic signed [VecW-1:0] y_i,
  input  wire logic signed [33:0]    z_i,
  input  wire logic [1:0]            quad_i,
  input  wire chpg_pkg::side_t       side_i,
  output logic signed      [VecW-1:0] x_o,
  output logic signed      [VecW-1:0] y_o,
  output logic signed      [33:0]    z_o,
  output logic [1:0]                 quad_o,
  output chpg_pkg::side_t            side_o
);
  localparam logic signed [33:0] Atan = 34'(chpg_pkg::atan_turn(Stage));
  logic signed [VecW-1:0] dx, dy;

  assign dx = y_i >>> Stage;
  assign dy = x_i >>> Stage;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!z_i[33]) begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - Atan;
      end else begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + Atan;
      end
      quad_o <= quad_i;
      side_o <= side_i;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/conical_helix_point_generator.sv -----
// conical_helix_point_generator: streaming helix point evaluator, one beat per cycle while the output is not stalled
// pipeline: 1 input + (12+FRAC_BITS) divider cells + 2 multiply stages + CORDIC_STAGES (capped at MaxStages) + 1 output
// throughput: one index per cycle; the whole chain advances when the output is free
// reset clears valid bits and loads register defaults; no clearing pass
// depends on chpg_pkg, chpg_div_cell, chpg_cordic_cell
`default_nettype none
module conical_helix_point_generator #(
  parameter int unsigned FRAC_BITS     = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [11:0] point_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [16:0] pos_x_o,
  output logic      [15:0] pos_y_o,
  output logic signed [16:0] pos_z_o,
  output logic             last_point_o,
  output logic             index_error_o
);
  localparam int unsigned NumW  = 12 + FRAC_BITS;
  localparam int unsigned TW    = FRAC_BITS + 1;
  localparam int unsigned PhBits = 9 + FRAC_BITS;
  localparam int unsigned VecW  = 40;
  localparam int unsigned NStg  = (CORDIC_STAGES < chpg_pkg::MaxStages) ?
                                  CORDIC_STAGES : chpg_pkg::MaxStages;
  localparam int unsigned Depth = 1 + NumW + 2 + NStg + 1;

  // registers
  logic [15:0] start_q, end_q, rise_q, rev_q;
  logic [11:0] total_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 16'd2048;
      end_q   <= 16'd2048;
      rise_q  <= 16'd2048;
      rev_q   <= 16'd1536;
      total_q <= 12'd64;
    end else if (wr) begin
      unique case (paddr[4:2])
        chpg_pkg::RegStartRadius: start_q <= pwdata[15:0];
        chpg_pkg::RegEndRadius:   end_q   <= pwdata[15:0];
        chpg_pkg::RegRiseHeight:  rise_q  <= pwdata[15:0];
        chpg_pkg::RegRevolutions: rev_q   <= pwdata[15:0];
        chpg_pkg::RegPointTotal:  total_q <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      chpg_pkg::RegStartRadius: prdata = {16'd0, start_q};
      chpg_pkg::RegEndRadius:   prdata = {16'd0, end_q};
      chpg_pkg::RegRiseHeight:  prdata = {16'd0, rise_q};
      chpg_pkg::RegRevolutions: prdata = {16'd0, rev_q};
      chpg_pkg::RegPointTotal:  prdata = {20'd0, total_q};
      default:                  prdata = '0;
    endcase
  end

  // whole chain moves in lockstep; a full output register held by out_stall_i stalls it
  logic adv;
  logic [Depth-1:0] vld_q;
  assign adv = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Depth-2:0], in_valid_i};
  end
  assign out_valid_o = vld_q[Depth-1];

  // input cell
  logic [11:0] total, den;
  assign total = (total_q < 12'd2) ? 12'd2 : total_q;
  logic [NumW-1:0] n0_q;
  logic [11:0]     den0_q, idx0_q;
  logic            err0_q, last0_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      n0_q    <= {point_index_i, {FRAC_BITS{1'b0}}};
      den0_q  <= total - 12'd1;
      idx0_q  <= point_index_i;
      err0_q  <= point_index_i >= total;
      last0_q <= point_index_i == total - 12'd1;
    end
  end
  assign den = den0_q;

  // divider chain, msb first
  logic [NumW-1:0] dn [NumW+1];
  logic [NumW-1:0] dq [NumW+1];
  logic [11:0]     dd [NumW+1];
  logic [11:0]     di [NumW+1];
  logic            de [NumW+1];
  logic            dl [NumW+1];
  assign dn[0] = n0_q;
  assign dq[0] = '0;
  assign dd[0] = den;
  assign di[0] = idx0_q;
  assign de[0] = err0_q;
  assign dl[0] = last0_q;

  for (genvar g = 0; g < NumW; g++) begin : g_div
    chpg_div_cell #(.NumW(NumW), .DenW(12), .Bit(NumW - 1 - g)) u_cell (
      .clk_i, .en_i(adv),
      .num_i(dn[g]), .quo_i(dq[g]), .den_i(dd[g]), .idx_i(di[g]),
      .err_i(de[g]), .last_i(dl[g]),
      .num_o(dn[g+1]), .quo_o(dq[g+1]), .den_o(dd[g+1]), .idx_o(di[g+1]),
      .err_o(de[g+1]), .last_o(dl[g+1])
    );
  end

  // multiply stage 1: products with t
  logic [TW-1:0] tq;
  assign tq = TW'(dq[NumW]);
  logic [15:0] diff;
  logic        down;
  assign down = end_q < start_q;
  assign diff = down ? 16'(start_q - end_q) : 16'(end_q - start_q);

  logic [TW+15:0]  rprod_q, yprod_q, pprod_q;
  logic            m1_err_q, m1_last_q, m1_down_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rprod_q   <= (TW+16)'(diff) * (TW+16)'(tq);
      yprod_q   <= (TW+16)'(rise_q) * (TW+16)'(tq);
      pprod_q   <= (TW+16)'(rev_q) * (TW+16)'(tq);
      m1_err_q  <= de[NumW];
      m1_last_q <= dl[NumW];
      m1_down_q <= down;
    end
  end

  // stage 2: radius, phase, gain multiply
  logic [16:0] rdelta, rad;
  assign rdelta = 17'(rprod_q >> FRAC_BITS);
  assign rad = m1_down_q ? 17'({1'b0, start_q} - rdelta) : 17'({1'b0, start_q} + rdelta);

  logic [PhBits-1:0] frac;
  logic [31:0]       phase;
  assign frac = PhBits'(pprod_q);
  if (PhBits >= 32) begin : g_ph_tr
    assign phase = 32'(frac >> (PhBits - 32));
  end else begin : g_ph_ext
    assign phase = {frac, {(32 - PhBits){1'b0}}};
  end

  // radius times cordic gain, both unsigned
  logic [33:0] gprod;
  assign gprod = {17'd0, rad} * 34'(chpg_pkg::GainQ16);

  logic signed [VecW-1:0] x0_q;
  logic signed [33:0]     z0_q;
  logic [1:0]             q0_q;
  chpg_pkg::side_t        s0_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x0_q <= $signed(VecW'(gprod));
      z0_q <= {4'd0, phase[29:0]};
      q0_q <= phase[31:30];
      s0_q.err   <= m1_err_q;
      s0_q.last  <= m1_last_q && !m1_err_q;
      s0_q.pos_y <= m1_err_q ? 16'd0 : 16'(yprod_q >> FRAC_BITS);
    end
  end

  // cordic chain
  logic signed [VecW-1:0] cx [NStg+1];
  logic signed [VecW-1:0] cy [NStg+1];
  logic signed [33:0]     cz [NStg+1];
  logic [1:0]             cq [NStg+1];
  chpg_pkg::side_t        cs [NStg+1];
  assign cx[0] = x0_q;
  assign cy[0] = '0;
  assign cz[0] = z0_q;
  assign cq[0] = q0_q;
  assign cs[0] = s0_q;

  for (genvar g = 0; g < NStg; g++) begin : g_cor
    chpg_cordic_cell #(.VecW(VecW), .Stage(g)) u_cell (
      .clk_i, .en_i(adv),
      .x_i(cx[g]), .y_i(cy[g]), .z_i(cz[g]), .quad_i(cq[g]), .side_i(cs[g]),
      .x_o(cx[g+1]), .y_o(cy[g+1]), .z_o(cz[g+1]), .quad_o(cq[g+1]), .side_o(cs[g+1])
    );
  end

  // quadrant fold, rounding, saturation
  logic signed [VecW-1:0] c, s;
  always_comb begin
    case (cq[NStg])
      2'd0:    begin c = cx[NStg];  s = cy[NStg];  end
      2'd1:    begin c = -cy[NStg]; s = cx[NStg];  end
      2'd2:    begin c = -cx[NStg]; s = -cy[NStg]; end
      default: begin c = cy[NStg];  s = -cx[NStg]; end
    endcase
  end

  function automatic logic signed [16:0] rnd_sat(input logic signed [VecW-1:0] v);
    logic signed [VecW-1:0] r;
    begin
      r = (v + VecW'(32768)) >>> 16;
      if (r > VecW'(65535)) return 17'sd65535;
      else if (r < -VecW'(65536)) return -17'sd65536;
      else return 17'(r);
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_x_o       <= cs[NStg].err ? 17'sd0 : rnd_sat(c);
      pos_z_o       <= cs[NStg].err ? 17'sd0 : rnd_sat(s);
      pos_y_o       <= cs[NStg].pos_y;
      last_point_o  <= cs[NStg].last;
      index_error_o <= cs[NStg].err;
    end
  end

  // checks
  a_err_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(last_point_o && index_error_o)) else $error("last and error both set");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && index_error_o) |-> (pos_x_o == 0 && pos_y_o == 0 && pos_z_o == 0))
    else $error("error beat has nonzero coordinates");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vld_q)) else $error("chain moved while stalled");

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// tb: self-checking bench for conical_helix_point_generator
// drives point indexes and apb register writes, predicts points in-bench and checks results
// depends on chpg_pkg and the rtl of the block
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int unsigned FracBits = 16;
  localparam int unsigned Stages   = 16;
  localparam int unsigned Latency  = 1 + (12 + FracBits) + 2 + Stages + 1;

  typedef struct packed {
    logic signed [16:0] x;
    logic [15:0]        y;
    logic signed [16:0] z;
    logic               last;
    logic               err;
  } point_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_stall_o;
  logic [11:0] point_index_i;
  logic out_valid_o, out_stall_i;
  logic signed [16:0] pos_x_o, pos_z_o;
  logic [15:0] pos_y_o;
  logic last_point_o, index_error_o;

  conical_helix_point_generator dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .point_index_i, .out_valid_o, .out_stall_i,
    .pos_x_o, .pos_y_o, .pos_z_o, .last_point_o, .index_error_o
  );

  // bench copy of the registers
  logic [15:0] start_r, end_r, rise_r, revs_r;
  logic [11:0] total_r;

  point_t expected_points[$];
  int errors = 0;
  int mismatches = 0;
  bit idle_en = 0;
  bit hold_out = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic logic signed [16:0] clamp17(longint v);
    if (v > 65535) v = 65535;
    if (v < -65536) v = -65536;
    return v[16:0];
  endfunction

  function automatic point_t helix_point(logic [11:0] idx);
    point_t p;
    longint unsigned total, tq, r, frac, phase;
    longint x, y, z, dx, dy, c, s;
    logic [1:0] quad;
    p = '0;
    total = (total_r < 2) ? 2 : total_r;
    if (idx >= total) begin
      p.err = 1'b1;
      return p;
    end
    tq = (longint'(idx) << FracBits) / (total - 1);
    if (end_r >= start_r) r = start_r + (((end_r - start_r) * tq) >> FracBits);
    else r = start_r - (((start_r - end_r) * tq) >> FracBits);
    frac = (revs_r * tq) & ((64'd1 << (9 + FracBits)) - 1);
    phase = (frac << (32 - 9 - FracBits)) & 64'hFFFF_FFFF;
    quad = phase[31:30];
    z = longint'(phase & 64'h3FFF_FFFF);
    x = longint'(r * chpg_pkg::GainQ16);
    y = 0;
    for (int i = 0; i < Stages; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(chpg_pkg::atan_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(chpg_pkg::atan_turn(i));
      end
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    p.x = clamp17(floor_shift(c + 32768, 16));
    p.y = 16'((rise_r * tq) >> FracBits);
    p.z = clamp17(floor_shift(s + 32768, 16));
    p.last = (idx == total - 1);
    return p;
  endfunction

  task automatic write_reg(chpg_pkg::reg_addr_e a, logic [31:0] v);
    @(negedge clk_i);
    psel = 1; penable = 0; pwrite = 1; paddr = {a, 2'b00}; pwdata = v;
    @(negedge clk_i);
    penable = 1;
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
    case (a)
      chpg_pkg::RegStartRadius: start_r = v[15:0];
      chpg_pkg::RegEndRadius:   end_r = v[15:0];
      chpg_pkg::RegRiseHeight:  rise_r = v[15:0];
      chpg_pkg::RegRevolutions: revs_r = v[15:0];
      default:                  total_r = v[11:0];
    endcase
  endtask

  task automatic drain();
    in_valid_i = 0;
    while (expected_points.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic load_helix(logic [15:0] sr, logic [15:0] er, logic [15:0] rh,
                            logic [15:0] rv, logic [11:0] pt);
    drain();
    write_reg(chpg_pkg::RegStartRadius, sr);
    write_reg(chpg_pkg::RegEndRadius, er);
    write_reg(chpg_pkg::RegRiseHeight, rh);
    write_reg(chpg_pkg::RegRevolutions, rv);
    write_reg(chpg_pkg::RegPointTotal, pt);
  endtask

  // one beat in; typed expectation used when given, else the predictor
  task automatic send_index(logic [11:0] idx, bit typed = 0, point_t want = '0);
    in_valid_i = 1;
    point_index_i = idx;
    do @(posedge clk_i); while (in_stall_o);
    expected_points.push_back(typed ? want : helix_point(idx));
    @(negedge clk_i);
    if (idle_en && $urandom_range(99) < 31) begin
      in_valid_i = 0;
      point_index_i = 12'($urandom);
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  // result side
  always @(posedge clk_i) begin
    point_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{pos_x_o, pos_y_o, pos_z_o, last_point_o, index_error_o};
      if (expected_points.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected beat %p", got);
      end else begin
        want = expected_points.pop_front();
        if (got !== want) begin
          errors++;
          if (mismatches++ < 10) $display("mismatch exp %p got %p", want, got);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_out) out_stall_i <= 1'b1;
    else out_stall_i <= idle_en && ($urandom_range(99) < 31);
  end

  typedef struct {
    logic [11:0] idx;
    bit          typed;
    point_t      want;
  } stim_row_t;

  stim_row_t directed[$];

  initial begin
    rst_ni = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid_i = 0; point_index_i = '0;
    start_r = 2048; end_r = 2048; rise_r = 2048; revs_r = 1536; total_r = 64;
    repeat (7) @(negedge clk_i);
    rst_ni = 1;

    // reset settings: first point sits at radius 2048 on the x axis, out of range is zero
    directed.push_back('{12'd0, 1, '{17'sd2048, 16'd0, 17'sd0, 1'b0, 1'b0}});
    directed.push_back('{12'd63, 0, '0});
    directed.push_back('{12'd64, 1, '{17'sd0, 16'd0, 17'sd0, 1'b0, 1'b1}});
    directed.push_back('{12'd4095, 1, '{17'sd0, 16'd0, 17'sd0, 1'b0, 1'b1}});
    directed.push_back('{12'd1, 0, '0});
    directed.push_back('{12'd32, 0, '0});
    foreach (directed[i]) send_index(directed[i].idx, directed[i].typed, directed[i].want);

    // extremes: widest cone, max turns, small point total treated as two
    load_helix(16'd40960, 16'd0, 16'd51200, 16'd32768, 12'd0);
    send_index(12'd0); send_index(12'd1); send_index(12'd2); send_index(12'd4095);
    load_helix(16'd0, 16'd40960, 16'd51200, 16'd0, 12'd1);
    send_index(12'd0); send_index(12'd1); send_index(12'd2);
    load_helix(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd4095);
    send_index(12'd0); send_index(12'd4094); send_index(12'd4095); send_index(12'd2047);
    load_helix(16'd0, 16'd0, 16'd0, 16'd1, 12'd2);
    send_index(12'd0); send_index(12'd1); send_index(12'd2);

    idle_en = 1;
    for (int ph = 0; ph < 6; ph++) begin
      load_helix(16'($urandom_range(0, 40960)), 16'($urandom_range(0, 40960)),
                 16'($urandom_range(0, 51200)), 16'($urandom_range(0, 32768)),
                 (ph == 2) ? 12'd4095 : 12'($urandom_range(2, 300)));
      if (ph == 1) begin
        // receiver holds off while the sender keeps offering
        fork
          begin
            hold_out = 1;
            repeat (200) @(negedge clk_i);
            hold_out = 0;
          end
          repeat (80) send_index(12'($urandom_range(0, total_r)));
        join
      end
      if (ph == 3) idle_en = 0;
      for (int n = 0; n < 110; n++) begin
        if ($urandom_range(9) == 0) send_index(12'($urandom));
        else send_index(12'($urandom_range(0, total_r - 1)));
      end
      idle_en = 1;
    end

    in_valid_i = 0;
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
